@@ rtl/sm4_pkg.sv @@
// sm4 shared types, constants and round functions
// used by sm4_ctrl, sm4_dpath and sm4_block_encrypt
`default_nettype none

package sm4_pkg;

    localparam int ROUND_COUNT = 32;
    localparam int RK_AW       = $clog2(ROUND_COUNT);

    localparam logic ACT_KEY_WRITE = 1'b0;
    localparam logic ACT_ENCRYPT   = 1'b1;

    typedef struct packed {
        logic              action;
        logic [RK_AW-1:0]  key_index;
        logic [31:0]       key_word;
        logic [63:0]       block_high;
        logic [63:0]       block_low;
    } t_in_word;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic             load;
        logic             round;
        logic             key_wr;
        logic             out_load;
        logic [RK_AW-1:0] rd_addr;
    } t_dp_cmd;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic logic [31:0] tau(input logic [31:0] v);
        tau = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    function automatic logic [31:0] diffuse(input logic [31:0] b);
        diffuse = b
                ^ {b[29:0], b[31:30]}
                ^ {b[21:0], b[31:22]}
                ^ {b[13:0], b[31:14]}
                ^ {b[7:0],  b[31:8]};
    endfunction

endpackage

`default_nettype wire

@@ rtl/sm4_ctrl.sv @@
// sm4 controller: handshakes, round counter and datapath commands
// depends on sm4_pkg
`default_nettype none

module sm4_ctrl
    import sm4_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_in_action,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_dp_cmd      o_cmd
);

    t_state            r_state, n_state;
    logic [RK_AW-1:0]  r_round, n_round;
    logic              r_out_valid, n_out_valid;
    logic              accept;

    localparam logic [RK_AW-1:0] LAST_ROUND = RK_AW'(ROUND_COUNT - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        n_state        = r_state;
        n_round        = r_round;
        o_cmd          = '0;
        unique case (r_state)
            ST_IDLE: begin
                n_round = '0;
                if (accept && i_in_action == ACT_KEY_WRITE) begin
                    o_cmd.key_wr = 1'b1;
                end
                if (accept && i_in_action == ACT_ENCRYPT) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.round   = 1'b1;
                o_cmd.rd_addr = r_round + 1'b1;
                n_round       = r_round + 1'b1;
                if (r_round == LAST_ROUND) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sm4_dpath.sv @@
// sm4 datapath: round key store, state words and output register
// depends on sm4_pkg, driven by sm4_ctrl
`default_nettype none

module sm4_dpath
    import sm4_pkg::*;
(
    input  wire logic     i_clk,
    input  t_dp_cmd       i_cmd,
    input  t_in_word      i_in_word,
    output t_out_word     o_out_word
);

    logic [31:0] r_rk_mem [ROUND_COUNT];
    logic [31:0] r_rk;
    logic [31:0] r_x0, r_x1, r_x2, r_x3;
    t_out_word   r_out;
    logic [31:0] n_x3;

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_wr) begin
            r_rk_mem[i_in_word.key_index] <= i_in_word.key_word;
        end
        r_rk <= r_rk_mem[i_cmd.rd_addr];
    end

    assign n_x3 = r_x0 ^ diffuse(tau(r_x1 ^ r_x2 ^ r_x3 ^ r_rk));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x0 <= i_in_word.block_high[63:32];
            r_x1 <= i_in_word.block_high[31:0];
            r_x2 <= i_in_word.block_low[63:32];
            r_x3 <= i_in_word.block_low[31:0];
        end else if (i_cmd.round) begin
            r_x0 <= r_x1;
            r_x1 <= r_x2;
            r_x2 <= r_x3;
            r_x3 <= n_x3;
        end
        if (i_cmd.out_load) begin
            r_out.cipher_high <= {r_x3, r_x2};
            r_out.cipher_low  <= {r_x1, r_x0};
        end
    end

    assign o_out_word = r_out;

endmodule

`default_nettype wire

@@ rtl/sm4_block_encrypt.sv @@
// sm4 block encryption top: key write at one word per cycle while idle
// encrypt: the block is loaded, ST_RUN does one round per cycle, then ST_FLUSH loads the output register
// a new block is accepted only in ST_IDLE, as the single round unit is shared by all rounds
// output register lets a new word be accepted while a result waits
// reset clears control state only, round key store holds no reset value
`default_nettype none

module sm4_block_encrypt
    import sm4_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  t_in_word      i_in_word,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_word     o_out_word
);

    t_dp_cmd cmd;

    sm4_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_action (i_in_word.action),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    sm4_dpath u_dpath (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_in_word  (i_in_word),
        .o_out_word (o_out_word)
    );

endmodule

`default_nettype wire
